### rtl/best_fit_block_allocator_unit_defines.svh
// assertion macros used by the allocator controller rtl
`ifndef BEST_FIT_BLOCK_ALLOCATOR_UNIT_DEFINES_SVH
`define BEST_FIT_BLOCK_ALLOCATOR_UNIT_DEFINES_SVH

// checked on every clock edge outside reset
`define BFBA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// checked on every clock edge, reset included
`define BFBA_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error(msg);

`endif

### rtl/bfba_pkg.sv
package bfba_pkg;

  localparam int unsigned HEAP_MAX_DEFAULT = 4096;
  localparam int unsigned HEAP_RESET       = 4096;
  localparam int unsigned HDR_BYTES        = 5;
  localparam int unsigned FIT_MARGIN       = 6;
  localparam int unsigned MIN_HEAP         = 16;

  localparam int unsigned SIZE_W   = 13;
  localparam int unsigned OFF_W    = 12;
  localparam int unsigned CFG_W    = 13;
  localparam int unsigned REQ_W    = SIZE_W + OFF_W;
  localparam int unsigned IN_TDATA_W  = 32;
  localparam int unsigned OUT_TDATA_W = 16;

  typedef enum logic {
    ACT_ALLOC = 1'b0,
    ACT_FREE  = 1'b1
  } action_e;

  // datapath commands issued by the controller
  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_INIT,
    CMD_ACCEPT,
    CMD_START,
    CMD_ALLOC_WALK,
    CMD_ALLOC_WR_BEST,
    CMD_ALLOC_WR_REST,
    CMD_FREE_WALK,
    CMD_MERGE_WALK,
    CMD_MERGE_NEXT
  } cmd_e;

  typedef struct packed {
    logic             more;      // next header lies inside the heap
    logic             used;      // used flag of the header just read
    logic             at_start;  // walk reached the block to free
    logic             past;      // walk went beyond the block to free
    logic             found;     // a fitting block was seen
    action_e          action;
    logic             off_low;   // free offset below header size
    logic [OFF_W-1:0] res_off;   // payload offset of the best block
  } status_t;

endpackage

### rtl/best_fit_block_allocator_unit.sv
// channel   | dir | signals                     | payload
// ----------+-----+-----------------------------+--------------------------------------
// request   | in  | s_axis_tvalid/tready/tdata  | tuser: action; tdata: size, offset
// result    | out | m_axis_tvalid/tready/tdata  | tdata: granted, result_offset
// config    | in  | cfg_we_i, cfg_wdata_i       | heap_bytes, no read-back
//
// one header is read per cycle while walking the block chain; the walk is set by
// the header store, whose registered read data feeds the next address
// allocate: walks every block of the chain, then on a fit writes the best block and its rest
// free: walk to the block plus a full merge walk that joins each run of free blocks
// after reset or a heap_bytes write the init state rebuilds the single free block
// one request in flight; a result waiting in the output register holds the next one
module best_fit_block_allocator_unit import bfba_pkg::*; #(
  parameter int unsigned HEAP_MAX_BYTES = HEAP_MAX_DEFAULT
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // request channel
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // request_size[12:0], payload_offset[24:13]
  input  logic                   s_axis_tuser,   // action: 0 allocate, 1 free
  // result channel
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // granted[0], result_offset[12:1]
  // heap size register
  input  logic                   cfg_we_i,
  input  logic [CFG_W-1:0]       cfg_wdata_i
);

  cmd_e    cmd;
  status_t status;

  // sequencer: walks, writes and result transfer
  bfba_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cmd_o         (cmd),
    .status_i      (status)
  );

  // header store, chain pointers and best-fit tracking
  bfba_datapath #(
    .HEAP_MAX_BYTES (HEAP_MAX_BYTES)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .req_data_i   (s_axis_tdata[REQ_W-1:0]),
    .req_action_i (action_e'(s_axis_tuser)),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .status_o     (status)
  );

endmodule

### rtl/bfba_datapath.sv
module bfba_datapath import bfba_pkg::*; #(
  parameter int unsigned HEAP_MAX_BYTES = HEAP_MAX_DEFAULT
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  cmd_e             cmd_i,
  input  logic [REQ_W-1:0] req_data_i,
  input  action_e          req_action_i,
  input  logic             cfg_we_i,
  input  logic [CFG_W-1:0] cfg_wdata_i,
  output status_t          status_o
);

  localparam int unsigned AW = $clog2(HEAP_MAX_BYTES);
  localparam int unsigned LW = $clog2(HEAP_MAX_BYTES + 1);
  localparam int unsigned CW = ((LW > SIZE_W) ? LW : SIZE_W) + 2;
  localparam int unsigned HEAP_INIT =
    (HEAP_RESET > HEAP_MAX_BYTES) ? HEAP_MAX_BYTES : HEAP_RESET;

  // header store: used flag on top, payload length below
  logic [LW:0] mem [HEAP_MAX_BYTES];
  logic [LW:0] rd_q;

  logic [LW-1:0]     heap_q, heap_d;
  logic [CW-1:0]     pos_q, acc_q, nxt_q, best_q, best_len_q;
  logic              found_q;
  logic [SIZE_W-1:0] size_q;
  logic [OFF_W-1:0]  off_q;
  action_e           act_q;

  logic          rd_used;
  logic [CW-1:0] rd_len, next_w, macc_w, mnext_w, start_w, heap_w, cfg_w;
  logic [CW-1:0] rest_w, size_w;
  logic          cand, more_w, ren, wen;
  logic [AW-1:0] raddr, waddr;
  logic [LW:0]   wdata;

  assign rd_used = rd_q[LW];
  assign rd_len  = CW'(rd_q[LW-1:0]);
  assign heap_w  = CW'(heap_q);
  assign size_w  = CW'(size_q);
  assign next_w  = pos_q + rd_len + CW'(HDR_BYTES);
  assign macc_w  = acc_q + rd_len + CW'(HDR_BYTES);
  assign mnext_w = pos_q + macc_w + CW'(HDR_BYTES);
  assign start_w = CW'(off_q) - CW'(HDR_BYTES);
  assign rest_w  = best_q + size_w + CW'(HDR_BYTES);
  assign cand    = !rd_used && (rd_len > size_w + CW'(FIT_MARGIN)) &&
                   (!found_q || rd_len < best_len_q);
  assign more_w  = (cmd_i == CMD_MERGE_NEXT) ? (mnext_w < heap_w) : (next_w < heap_w);

  // heap size clamp on write
  assign cfg_w  = CW'(cfg_wdata_i);
  assign heap_d = (cfg_w < CW'(MIN_HEAP))       ? LW'(MIN_HEAP) :
                  (cfg_w > CW'(HEAP_MAX_BYTES)) ? LW'(HEAP_MAX_BYTES) :
                  LW'(cfg_wdata_i);

  always_comb begin
    ren   = 1'b0;
    raddr = '0;
    wen   = 1'b0;
    waddr = '0;
    wdata = '0;
    case (cmd_i)
      CMD_INIT: begin
        wen   = 1'b1;
        wdata = {1'b0, heap_q - LW'(HDR_BYTES)};
      end
      CMD_ACCEPT, CMD_START: begin
        ren = 1'b1;
      end
      CMD_ALLOC_WALK, CMD_MERGE_WALK: begin
        ren   = more_w;
        raddr = next_w[AW-1:0];
      end
      CMD_FREE_WALK: begin
        ren   = more_w;
        raddr = next_w[AW-1:0];
        if (pos_q == start_w && rd_used) begin
          wen   = 1'b1;
          waddr = pos_q[AW-1:0];
          wdata = {1'b0, rd_q[LW-1:0]};
        end
      end
      CMD_MERGE_NEXT: begin
        raddr = mnext_w[AW-1:0];
        waddr = pos_q[AW-1:0];
        if (rd_used) begin
          wen   = 1'b1;
          wdata = {1'b0, acc_q[LW-1:0]};
        end else begin
          ren = more_w;
          if (!more_w) begin
            wen   = 1'b1;
            wdata = {1'b0, macc_w[LW-1:0]};
          end
        end
      end
      CMD_ALLOC_WR_BEST: begin
        wen   = 1'b1;
        waddr = best_q[AW-1:0];
        wdata = {1'b1, LW'(size_q)};
      end
      CMD_ALLOC_WR_REST: begin
        wen   = (rest_w < CW'(HEAP_MAX_BYTES));
        waddr = rest_w[AW-1:0];
        wdata = {1'b0, LW'(best_len_q - size_w - CW'(HDR_BYTES))};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (wen) mem[waddr] <= wdata;
    if (ren) rd_q <= mem[raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      heap_q  <= LW'(HEAP_INIT);
      found_q <= 1'b0;
    end else begin
      if (cfg_we_i) heap_q <= heap_d;
      if (cmd_i == CMD_ACCEPT || cmd_i == CMD_START) found_q <= 1'b0;
      else if (cmd_i == CMD_ALLOC_WALK && cand) found_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i)
      CMD_ACCEPT: begin
        size_q <= req_data_i[SIZE_W-1:0];
        off_q  <= req_data_i[REQ_W-1:SIZE_W];
        act_q  <= req_action_i;
        pos_q  <= '0;
      end
      CMD_START: pos_q <= '0;
      CMD_ALLOC_WALK: begin
        pos_q <= next_w;
        if (cand) begin
          best_q     <= pos_q;
          best_len_q <= rd_len;
        end
      end
      CMD_FREE_WALK: pos_q <= next_w;
      CMD_MERGE_WALK: begin
        if (rd_used) begin
          pos_q <= next_w;
        end else begin
          acc_q <= rd_len;
          nxt_q <= next_w;
        end
      end
      CMD_MERGE_NEXT: begin
        if (rd_used) begin
          pos_q <= nxt_q;
        end else begin
          acc_q <= macc_w;
          nxt_q <= mnext_w;
        end
      end
      default: ;
    endcase
  end

  assign status_o.more     = more_w;
  assign status_o.used     = rd_used;
  assign status_o.at_start = (pos_q == start_w);
  assign status_o.past     = (pos_q > start_w);
  assign status_o.found    = found_q;
  assign status_o.action   = act_q;
  assign status_o.off_low  = (CW'(off_q) < CW'(HDR_BYTES));
  assign status_o.res_off  = OFF_W'(best_q + CW'(HDR_BYTES));

endmodule

### rtl/bfba_ctrl.sv
`include "best_fit_block_allocator_unit_defines.svh"

module bfba_ctrl import bfba_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,
  input  logic                   cfg_we_i,
  output cmd_e                   cmd_o,
  input  status_t                status_i
);

  typedef enum logic [3:0] {
    S_INIT, S_IDLE, S_DISPATCH, S_A_WALK, S_A_FIN, S_A_WR_BEST, S_A_WR_REST,
    S_F_WALK, S_M_START, S_M_WALK, S_M_NEXT, S_DONE
  } state_e;

  state_e                 state_q, state_d;
  logic                   ok_q, ok_d;
  logic                   m_valid_q;
  logic [OUT_TDATA_W-1:0] m_data_q;
  logic                   load_out;

  assign s_axis_tready = (state_q == S_IDLE) && !cfg_we_i;
  assign load_out      = (state_q == S_DONE) && (!m_valid_q || m_axis_tready);

  always_comb begin
    state_d = state_q;
    ok_d    = ok_q;
    cmd_o   = CMD_NONE;
    unique case (state_q)
      S_INIT: begin
        cmd_o = CMD_INIT;
        if (!cfg_we_i) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (cfg_we_i) begin
          state_d = S_INIT;
        end else if (s_axis_tvalid) begin
          cmd_o   = CMD_ACCEPT;
          state_d = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        ok_d = 1'b0;
        if (status_i.action == ACT_ALLOC) state_d = S_A_WALK;
        else if (status_i.off_low)        state_d = S_DONE;
        else                              state_d = S_F_WALK;
      end
      S_A_WALK: begin
        cmd_o = CMD_ALLOC_WALK;
        if (!status_i.more) state_d = S_A_FIN;
      end
      S_A_FIN: state_d = status_i.found ? S_A_WR_BEST : S_DONE;
      S_A_WR_BEST: begin
        cmd_o   = CMD_ALLOC_WR_BEST;
        state_d = S_A_WR_REST;
      end
      S_A_WR_REST: begin
        cmd_o   = CMD_ALLOC_WR_REST;
        ok_d    = 1'b1;
        state_d = S_DONE;
      end
      S_F_WALK: begin
        cmd_o = CMD_FREE_WALK;
        if (status_i.at_start) begin
          state_d = status_i.used ? S_M_START : S_DONE;
        end else if (status_i.past || !status_i.more) begin
          state_d = S_DONE;
        end
      end
      S_M_START: begin
        cmd_o   = CMD_START;
        ok_d    = 1'b1;
        state_d = S_M_WALK;
      end
      S_M_WALK: begin
        cmd_o = CMD_MERGE_WALK;
        if (!status_i.more)      state_d = S_DONE;
        else if (!status_i.used) state_d = S_M_NEXT;
      end
      S_M_NEXT: begin
        cmd_o = CMD_MERGE_NEXT;
        if (status_i.used)      state_d = S_M_WALK;
        else if (!status_i.more) state_d = S_DONE;
      end
      S_DONE: begin
        if (load_out) state_d = S_IDLE;
      end
      default: state_d = S_INIT;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_INIT;
      ok_q      <= 1'b0;
      m_valid_q <= 1'b0;
      m_data_q  <= '0;
    end else begin
      state_q <= state_d;
      ok_q    <= ok_d;
      if (load_out) begin
        m_valid_q <= 1'b1;
        m_data_q  <= OUT_TDATA_W'({
          ((ok_q && status_i.action == ACT_ALLOC) ? status_i.res_off : '0), ok_q});
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

  `BFBA_ASSERT(a_done_holds, (state_q == S_DONE && m_valid_q && !m_axis_tready) |=> (state_q == S_DONE), "finished result lost while output busy")
  `BFBA_ASSERT(a_accept_dispatch, (s_axis_tvalid && s_axis_tready && !cfg_we_i) |=> (state_q == S_DISPATCH), "accepted request not dispatched")
  `BFBA_ASSERT(a_refused_zero, (m_valid_q && !m_data_q[0]) |-> (m_data_q[OFF_W:1] == '0), "refused result carries an offset")
  `BFBA_ASSERT_ALWAYS(a_reset_quiet, !rst_ni |-> (!m_valid_q && !s_axis_tready), "handshake active in reset")

endmodule

### tb/sv/best_fit_block_allocator_unit_tb.sv
`timescale 1ns / 1ps

module best_fit_block_allocator_unit_tb;
  import bfba_pkg::*;

  localparam int unsigned HEAP_MAX  = HEAP_MAX_DEFAULT;
  localparam int unsigned N_RANDOM  = 700;
  localparam int unsigned CYC_LIMIT = 10_000_000;

  logic                   clk_i;
  logic                   rst_ni;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata;   // request_size[12:0], payload_offset[24:13]
  logic                   s_axis_tuser;   // action
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;   // granted[0], result_offset[12:1]
  logic                   cfg_we_i;
  logic [CFG_W-1:0]       cfg_wdata_i;

  best_fit_block_allocator_unit #(.HEAP_MAX_BYTES(HEAP_MAX)) DUT (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .cfg_we_i, .cfg_wdata_i
  );

  typedef struct packed {
    logic             granted;
    logic [OFF_W-1:0] offset;
  } grant_t;

  // ---------------------------------------------------------------------------
  // heap shadow: in-band block chain kept in the testbench
  // ---------------------------------------------------------------------------
  int unsigned heap_size;
  bit          blk_used [HEAP_MAX];
  int unsigned blk_len  [HEAP_MAX];
  int unsigned live_offsets[$];   // payload offsets currently allocated

  function automatic int unsigned clamp_heap(int unsigned v);
    if (v < MIN_HEAP) return MIN_HEAP;
    if (v > HEAP_MAX) return HEAP_MAX;
    return v;
  endfunction

  function automatic void rebuild_heap(int unsigned bytes);
    heap_size = clamp_heap(bytes);
    foreach (blk_used[i]) begin
      blk_used[i] = 1'b0;
      blk_len[i]  = 0;
    end
    blk_len[0] = heap_size - HDR_BYTES;
    live_offsets.delete();
  endfunction

  function automatic void coalesce_free_runs();
    int unsigned pos, len, nxt;
    pos = 0;
    while (pos < heap_size && pos < HEAP_MAX) begin
      len = blk_len[pos];
      if (!blk_used[pos]) begin
        nxt = pos + len + HDR_BYTES;
        while (nxt < heap_size && nxt < HEAP_MAX && !blk_used[nxt]) begin
          len += blk_len[nxt] + HDR_BYTES;
          nxt = pos + len + HDR_BYTES;
        end
        blk_len[pos] = len;
      end
      pos += len + HDR_BYTES;
    end
  endfunction

  // best fit: smallest free block longer than size + margin, first on ties
  function automatic grant_t predict_alloc(int unsigned size);
    int unsigned pos, best, best_len, rest;
    bit          found;
    grant_t      g;
    pos = 0; best = 0; best_len = 0; found = 0; g = '0;
    while (pos < heap_size && pos < HEAP_MAX) begin
      if (!blk_used[pos] && blk_len[pos] > size + FIT_MARGIN &&
          (!found || blk_len[pos] < best_len)) begin
        found = 1; best = pos; best_len = blk_len[pos];
      end
      pos += blk_len[pos] + HDR_BYTES;
    end
    if (!found) return g;
    rest = best + size + HDR_BYTES;
    blk_used[best] = 1'b1;
    blk_len[best]  = size;
    if (rest < HEAP_MAX) begin
      blk_used[rest] = 1'b0;
      blk_len[rest]  = best_len - size - HDR_BYTES;
    end
    g.granted = 1'b1;
    g.offset  = OFF_W'(best + HDR_BYTES);
    live_offsets.push_back(best + HDR_BYTES);
    return g;
  endfunction

  function automatic grant_t predict_free(int unsigned off);
    int unsigned pos, start;
    grant_t      g;
    g = '0; pos = 0;
    if (off < HDR_BYTES) return g;
    start = off - HDR_BYTES;
    while (pos < heap_size && pos < HEAP_MAX) begin
      if (pos == start) begin
        if (!blk_used[pos]) return g;
        blk_used[pos] = 1'b0;
        coalesce_free_runs();
        foreach (live_offsets[i])
          if (live_offsets[i] == off) begin
            live_offsets.delete(i);
            break;
          end
        g.granted = 1'b1;
        return g;
      end
      if (pos > start) return g;
      pos += blk_len[pos] + HDR_BYTES;
    end
    return g;
  endfunction

  // ---------------------------------------------------------------------------
  // clock, reset, cycle limit
  // ---------------------------------------------------------------------------
  int unsigned cycle_cnt;
  int unsigned err_cnt;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYC_LIMIT) begin
      $display("[best_fit_block_allocator_unit] ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // idling control shared by both sides
  // ---------------------------------------------------------------------------
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  bit          hold_off;        // long receiver stall for back-pressure

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // result checking against the queue of predicted grants
  // ---------------------------------------------------------------------------
  grant_t pending_grants[$];

  always @(posedge clk_i) begin
    grant_t want, got;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.granted = m_axis_tdata[0];
      got.offset  = m_axis_tdata[OFF_W:1];
      if (pending_grants.size() == 0) begin
        $error("result transfer with no request waiting: %h", m_axis_tdata);
        err_cnt++;
      end else begin
        want = pending_grants.pop_front();
        if (got.granted !== want.granted) begin
          $error("granted: expected %0d actual %0d", want.granted, got.granted);
          err_cnt++;
        end
        if (got.offset !== want.offset) begin
          $error("result_offset: expected %0d actual %0d", want.offset, got.offset);
          err_cnt++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // request driving
  // ---------------------------------------------------------------------------
  // one request transfer; prediction is made at acceptance, in request order
  // tvalid stays up after a transfer unless the sender idles or the sequence ends
  task automatic send_request(action_e act, int unsigned size, int unsigned off,
                              bit has_fixed, grant_t fixed);
    grant_t g;
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= act;
    s_axis_tdata  <= {7'b0, off[OFF_W-1:0], size[SIZE_W-1:0]};
    do @(posedge clk_i); while (!s_axis_tready);
    g = (act == ACT_ALLOC) ? predict_alloc(size) : predict_free(off);
    if (has_fixed && g !== fixed) begin
      $error("directed row: expected %p, predictor gives %p", fixed, g);
      err_cnt++;
    end
    pending_grants.push_back(g);
  endtask

  // wait out every result, then the worst walk, before touching the register
  task automatic drain_and_settle();
    s_axis_tvalid <= 1'b0;
    while (pending_grants.size() != 0) @(posedge clk_i);
    repeat (2 * HEAP_MAX / HDR_BYTES + 20) @(posedge clk_i);
  endtask

  task automatic write_heap_bytes(int unsigned v);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= CFG_W'(v);
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    rebuild_heap(v[CFG_W-1:0]);
    @(posedge clk_i);
  endtask

  // directed table: fixed grants only where plain to read off
  typedef struct {
    action_e     act;
    int unsigned size;
    int unsigned off;
    bit          has_fixed;
    grant_t      fixed;
  } stim_row_t;

  stim_row_t dir_rows[] = '{
    '{ACT_FREE,  0,    5,    1, '{1'b0, 12'd0}},    // free on an empty heap
    '{ACT_FREE,  0,    0,    1, '{1'b0, 12'd0}},    // offset below header size
    '{ACT_ALLOC, 0,    0,    1, '{1'b1, 12'd5}},    // zero-byte block at heap start
    '{ACT_ALLOC, 100,  0,    1, '{1'b1, 12'd10}},
    '{ACT_ALLOC, 8191, 4095, 1, '{1'b0, 12'd0}},    // all request bits set, no fit
    '{ACT_ALLOC, 4096, 0,    1, '{1'b0, 12'd0}},
    '{ACT_FREE,  0,    11,   1, '{1'b0, 12'd0}},    // not a block start
    '{ACT_FREE,  0,    4095, 1, '{1'b0, 12'd0}},
    '{ACT_FREE,  0,    5,    1, '{1'b1, 12'd0}},
    '{ACT_FREE,  0,    5,    1, '{1'b0, 12'd0}},    // double free
    '{ACT_ALLOC, 20,   0,    0, '{1'b0, 12'd0}},
    '{ACT_ALLOC, 3900, 0,    0, '{1'b0, 12'd0}},
    '{ACT_FREE,  0,    10,   1, '{1'b1, 12'd0}},    // merges with the free neighbor
    '{ACT_ALLOC, 3960, 0,    0, '{1'b0, 12'd0}},
    '{ACT_ALLOC, 4084, 0,    1, '{1'b0, 12'd0}}     // fit needs length above size + 6
  };

  // random request: half allocations, the rest mostly well-formed frees of live blocks
  task automatic send_random_request();
    int unsigned r, sz, off;
    r = $urandom_range(99);
    if (r < 50) begin
      sz = ($urandom_range(19) == 0) ? $urandom_range(8191) :
           ($urandom_range(3) == 0) ? $urandom_range(heap_size) :
                                      $urandom_range(heap_size / 8);
      send_request(ACT_ALLOC, sz, $urandom_range(4095), 0, '0);
    end else if (r < 88 && live_offsets.size() != 0) begin
      off = live_offsets[$urandom_range(live_offsets.size() - 1)];
      send_request(ACT_FREE, $urandom_range(8191), off, 0, '0);
    end else begin
      send_request(ACT_FREE, $urandom_range(8191), $urandom_range(4095), 0, '0);
    end
  endtask

  int unsigned heap_settings[] = '{4096, 16, 0, 8191, 200, 1000, 4095};
  int unsigned idle_modes[4][2] = '{'{0, 0}, '{64, 0}, '{0, 64}, '{12, 12}};

  initial begin
    rst_ni         = 1'b0;
    s_axis_tvalid  = 1'b0;
    s_axis_tdata   = '0;
    s_axis_tuser   = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_wdata_i    = '0;
    cycle_cnt      = 0;
    err_cnt        = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_off       = 1'b0;
    rebuild_heap(HEAP_RESET);
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (3) @(posedge clk_i);

    // directed part at the reset heap size
    foreach (dir_rows[i])
      send_request(dir_rows[i].act, dir_rows[i].size, dir_rows[i].off,
                   dir_rows[i].has_fixed, dir_rows[i].fixed);
    drain_and_settle();

    // random part: every heap setting, idling modes rotating
    for (int p = 0; p < heap_settings.size(); p++) begin
      write_heap_bytes(heap_settings[p]);
      for (int m = 0; m < 4; m++) begin
        send_idle_pct  = idle_modes[m][0];
        recv_stall_pct = idle_modes[m][1];
        for (int n = 0; n < N_RANDOM / 28; n++) send_random_request();
      end
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      drain_and_settle();
    end

    // back-pressure: receiver holds off while requests keep coming
    fork
      begin
        hold_off = 1'b1;
        repeat (4000) @(posedge clk_i);
        hold_off = 1'b0;
      end
      for (int n = 0; n < 12; n++) send_random_request();
    join
    drain_and_settle();

    if (err_cnt == 0) begin
      $display("[best_fit_block_allocator_unit] OK");
    end else begin
      $display("[best_fit_block_allocator_unit] ERROR");
    end
    $finish;
  end

endmodule

### files.f
+incdir+rtl
rtl/bfba_pkg.sv
rtl/bfba_datapath.sv
rtl/bfba_ctrl.sv
rtl/best_fit_block_allocator_unit.sv
tb/sv/best_fit_block_allocator_unit_tb.sv
